/* sv/sht_pkg.sv */
`timescale 1ns / 1ps

package sht_pkg;

  localparam int unsigned ENTRIES = 65536;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);

  localparam logic [14:0] MATE_RESET = 15'd31000;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [1:0] BOUND_NONE = 2'd0;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] eval;
    logic [15:0] score;
    logic [15:0] move;
    logic [63:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* sv/sht_ram.sv */
`timescale 1ns / 1ps

module sht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/search_hash_table_store.sv */
`timescale 1ns / 1ps

// channel   dir  word                          fields, lowest bit up
// s_axis    in   tuser[1:0], tdata[135:0]      opcode | key, ply, best_move,
//                                              search_depth, score_in, eval_in, bound_in
// m_axis    out  tuser[0], tdata[63:0]         hit | move_out, score_out, eval_out,
//                                              depth_out, bound_out
// cfg       in   data[14:0]                    mate_threshold
//
// Probe and write first read the slot RAM as the word is taken; then, once
// the output register is free, they modify, write back and load the output register.
// Reset and clear sweep the RAM one slot a cycle over all ENTRIES slots (65536),
// during which s_axis_tready is low; clear then returns its result word.
// A stalled m_axis holds the result; the next input word is still taken.

module search_hash_table_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [1:0]                       s_axis_tuser,  // opcode
  input  logic [sht_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key, ply, best_move, search_depth,
                                                           // score_in, eval_in, bound_in, pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic                             m_axis_tuser,  // hit
  output logic [sht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // move_out, score_out, eval_out,
                                                           // depth_out, bound_out, pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [14:0]                      cfg_data       // mate_threshold
);

  localparam int unsigned OUT_W = sht_pkg::OUT_DATA_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  state_t                    state;
  logic [sht_pkg::IDX_W-1:0] clr_cnt;
  logic                      clr_resp;
  sht_pkg::op_t              op_r;
  logic [63:0]               key_r;
  logic [7:0]                ply_r;
  logic [15:0]               mv_r;
  logic [7:0]                dp_r;
  logic [15:0]               sc_r;
  logic [15:0]               ev_r;
  logic [1:0]                bd_r;
  logic [14:0]               thr;

  logic                        ram_we;
  logic [sht_pkg::IDX_W-1:0]   ram_addr;
  sht_pkg::entry_t             ram_wdata;
  logic [sht_pkg::ENTRY_W-1:0] ram_rdata;
  sht_pkg::entry_t             rd;
  sht_pkg::entry_t             wr_entry;
  logic                        accept;
  logic                        advance;
  logic                        hit_next;
  logic [OUT_W-1:0]            data_next;

  function automatic logic [15:0] mate_shift(input logic [15:0] s, input logic [7:0] ply,
                                             input logic [14:0] th, input logic away);
    logic [16:0] mag;
    logic        pos;
    begin
      mag = s[15] ? (17'd0 - {s[15], s}) : {1'b0, s};
      pos = !s[15] && (s != 16'd0);
      if (mag < {2'b00, th}) begin
        mate_shift = s;
      end else if (pos == away) begin
        mate_shift = s + {8'd0, ply};
      end else begin
        mate_shift = s - {8'd0, ply};
      end
    end
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);
  assign rd            = sht_pkg::entry_t'(ram_rdata);

  always_comb begin
    wr_entry.key   = key_r;
    wr_entry.move  = ((mv_r == 16'd0) && (rd.key == key_r)) ? rd.move : mv_r;
    wr_entry.score = mate_shift(sc_r, ply_r, thr, 1'b1);
    wr_entry.eval  = ev_r;
    wr_entry.depth = dp_r;
    wr_entry.bound = bd_r;
  end

  always_comb begin
    hit_next  = 1'b0;
    data_next = '0;
    case (op_r)
      sht_pkg::OP_PROBE: begin
        if ((rd.bound != sht_pkg::BOUND_NONE) && (rd.key == key_r)) begin
          hit_next  = 1'b1;
          data_next = OUT_W'({rd.bound, rd.depth, rd.eval,
                              mate_shift(rd.score, ply_r, thr, 1'b0), rd.move});
        end
      end
      default: begin
        hit_next  = 1'b0;
        data_next = '0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      S_RESP: begin
        ram_we    = advance && (op_r == sht_pkg::OP_WRITE);
        ram_wdata = wr_entry;
        ram_addr  = key_r[sht_pkg::IDX_W-1:0];
      end
      default: begin
        ram_addr = s_axis_tdata[sht_pkg::IDX_W-1:0];
      end
    endcase
  end

  sht_ram #(
    .WIDTH (sht_pkg::ENTRY_W),
    .DEPTH (sht_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      clr_resp      <= 1'b0;
      thr           <= sht_pkg::MATE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == sht_pkg::IDX_W'(sht_pkg::ENTRIES - 1)) begin
            state    <= clr_resp ? S_RESP : S_IDLE;
            clr_resp <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (sht_pkg::op_t'(s_axis_tuser) == sht_pkg::OP_CLEAR) begin
              state    <= S_CLEAR;
              clr_cnt  <= '0;
              clr_resp <= 1'b1;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= sht_pkg::op_t'(s_axis_tuser);
      key_r <= s_axis_tdata[63:0];
      ply_r <= s_axis_tdata[71:64];
      mv_r  <= s_axis_tdata[87:72];
      dp_r  <= s_axis_tdata[95:88];
      sc_r  <= s_axis_tdata[111:96];
      ev_r  <= s_axis_tdata[127:112];
      bd_r  <= s_axis_tdata[129:128];
    end
    if (advance) begin
      m_axis_tuser <= hit_next;
      m_axis_tdata <= data_next;
    end
  end

endmodule

/* sv/sht_checker.sv */
`timescale 1ns / 1ps

module sht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic [63:0] m_axis_tdata
);

  a_reset_out_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_hit_has_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[57:56] != sht_pkg::BOUND_NONE)
    else $error("hit reported with bound none");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("miss or non-probe word carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word in flight");

endmodule

bind search_hash_table_store sht_checker u_sht_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);

/* bench/search_hash_table_store_checker.sv */
`timescale 1ns / 1ps

module search_hash_table_store_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [1:0]                     s_axis_tuser,  // opcode
  input  logic [sht_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key, ply, best_move, search_depth,
                                                        // score_in, eval_in, bound_in, pad
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           m_axis_tuser,  // hit
  input  logic [sht_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // move_out, score_out, eval_out,
                                                        // depth_out, bound_out, pad
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [14:0]                    cfg_data,      // mate_threshold
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic        hit;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] eval;
    logic [15:0] score;
    logic [15:0] move;
  } lookup_t;

  sht_pkg::entry_t    slot_store [bit [sht_pkg::IDX_W-1:0]];
  lookup_t            lookups [$];
  logic [14:0]        mate_limit;

  function automatic sht_pkg::entry_t read_slot(logic [sht_pkg::IDX_W-1:0] idx);
    if (slot_store.exists(idx)) begin
      return slot_store[idx];
    end
    return '0;
  endfunction

  function automatic logic [15:0] mate_adjust(logic [15:0] s, logic [7:0] ply, bit away);
    int v;
    int mag;
    v = int'($signed(s));
    mag = (v < 0) ? -v : v;
    if (mag < int'(mate_limit)) begin
      return s;
    end
    if ((v > 0) == away) begin
      return s + {8'd0, ply};
    end
    return s - {8'd0, ply};
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [1:0]                op;
    logic [63:0]               key;
    logic [7:0]                ply;
    logic [15:0]               mv;
    logic [sht_pkg::IDX_W-1:0] idx;
    sht_pkg::entry_t           slot;
    lookup_t                   want;
    lookup_t                   got;
    if (rst) begin
      mate_limit = sht_pkg::MATE_RESET;
      slot_store.delete();
      lookups.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mate_limit = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op   = s_axis_tuser;
        key  = s_axis_tdata[63:0];
        ply  = s_axis_tdata[71:64];
        mv   = s_axis_tdata[87:72];
        idx  = key[sht_pkg::IDX_W-1:0];
        slot = read_slot(idx);
        want = '0;
        case (op)
          sht_pkg::OP_PROBE: begin
            if (slot.bound != sht_pkg::BOUND_NONE && slot.key == key) begin
              want.hit   = 1'b1;
              want.move  = slot.move;
              want.score = mate_adjust(slot.score, ply, 1'b0);
              want.eval  = slot.eval;
              want.depth = slot.depth;
              want.bound = slot.bound;
            end
          end
          sht_pkg::OP_WRITE: begin
            if (mv == '0 && slot.key == key) begin
              mv = slot.move;
            end
            slot.key   = key;
            slot.move  = mv;
            slot.depth = s_axis_tdata[95:88];
            slot.score = mate_adjust(s_axis_tdata[111:96], ply, 1'b1);
            slot.eval  = s_axis_tdata[127:112];
            slot.bound = s_axis_tdata[129:128];
            slot_store[idx] = slot;
          end
          sht_pkg::OP_CLEAR: begin
            slot_store.delete();
          end
          default: begin
          end
        endcase
        lookups.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit   = m_axis_tuser;
        got.move  = m_axis_tdata[15:0];
        got.score = m_axis_tdata[31:16];
        got.eval  = m_axis_tdata[47:32];
        got.depth = m_axis_tdata[55:48];
        got.bound = m_axis_tdata[57:56];
        if (lookups.size() == 0) begin
          errors++;
          $display("%0t: result word expected none, got hit %0b data %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = lookups.pop_front();
          check_field("hit", 16'(want.hit), 16'(got.hit));
          check_field("move_out", want.move, got.move);
          check_field("score_out", want.score, got.score);
          check_field("eval_out", want.eval, got.eval);
          check_field("depth_out", 16'(want.depth), 16'(got.depth));
          check_field("bound_out", 16'(want.bound), 16'(got.bound));
        end
      end
    end
    pending = lookups.size();
  end

endmodule

/* bench/tb_search_hash_table_store.sv */
`timescale 1ns / 1ps

module tb_search_hash_table_store;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam int WATCHDOG_LIMIT = 4 * sht_pkg::ENTRIES;
  localparam int POOL_SIZE      = 32;
  localparam int PHASE_ITEMS    = 350;

  localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_1234;
  localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_1234;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [1:0]                     s_axis_tuser = '0;
  logic [sht_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           m_axis_tuser;
  logic [sht_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [14:0]                    cfg_data = '0;

  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  logic [14:0] threshold_now = sht_pkg::MATE_RESET;
  logic [63:0] key_pool [POOL_SIZE];
  logic [14:0] phase_limits [5];

  search_hash_table_store u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  search_hash_table_store_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("search_hash_table_store: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [63:0] key,
                          input logic [7:0] ply, input logic [15:0] move,
                          input logic [7:0] depth, input logic [15:0] score,
                          input logic [15:0] eval, input logic [1:0] bound);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, bound, eval, score, depth, move, ply, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every result word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [14:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    threshold_now = value;
  endtask

  task automatic random_req();
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] score;
    logic [15:0] move;
    int          r;
    r = $urandom_range(999);
    if (r < 2) begin
      op = sht_pkg::OP_CLEAR;
    end else if (r < 30) begin
      op = OP_UNUSED;
    end else if (r < 520) begin
      op = sht_pkg::OP_WRITE;
    end else begin
      op = sht_pkg::OP_PROBE;
    end
    r = $urandom_range(99);
    if (r < 80) begin
      key = key_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (r < 95) begin
      key = {$urandom, $urandom};
    end else if (r < 98) begin
      key = '0;
    end else begin
      key = '1;
    end
    case ($urandom_range(4))
      0: score = 16'($urandom);
      1: score = 16'(int'(threshold_now) + int'($urandom_range(4)) - 2);
      2: score = 16'(-int'(threshold_now) + int'($urandom_range(4)) - 2);
      3: begin
        case ($urandom_range(3))
          0: score = 16'h7FFF;
          1: score = 16'h8000;
          2: score = 16'h8001;
          default: score = 16'h0000;
        endcase
      end
      default: score = 16'(int'($urandom_range(2000)) - 1000);
    endcase
    move = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    send_req(op, key, 8'($urandom), move, 8'($urandom), score, 16'($urandom),
             2'($urandom));
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i % 2 == 1) begin
        key_pool[i][sht_pkg::IDX_W-1:0] = key_pool[i-1][sht_pkg::IDX_W-1:0];
      end
    end
    phase_limits = '{15'd0, 15'h7FFF, 15'd1, 15'($urandom_range(32767)),
                     sht_pkg::MATE_RESET};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_req(sht_pkg::OP_PROBE, 64'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, KEY_A, 8'd5, 16'h1111, 8'd10, 16'd31000, 16'd100, BOUND_EXACT);
    send_req(sht_pkg::OP_PROBE, KEY_A, 8'd3, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, KEY_A, 8'd0, 16'd0, 8'd3, -16'sd31000, 16'd7, BOUND_LOWER);
    send_req(sht_pkg::OP_PROBE, KEY_A, 8'd7, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, KEY_B, 8'd4, 16'd0, 8'd1, 16'd30999, 16'd5, BOUND_UPPER);
    send_req(sht_pkg::OP_PROBE, KEY_A, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_PROBE, KEY_B, 8'd9, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, KEY_B, 8'd1, 16'h2222, 8'd2, 16'd50, 16'd6,
             sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_PROBE, KEY_B, 8'd1, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, '1, 8'd255, 16'hFFFF, 8'h80, 16'h8000, 16'h8000, BOUND_EXACT);
    send_req(sht_pkg::OP_PROBE, '1, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_WRITE, 64'd0, 8'd255, 16'd0, 8'h7F, 16'h7FFF, 16'h7FFF, BOUND_LOWER);
    send_req(sht_pkg::OP_PROBE, 64'd0, 8'd255, 16'd0, 8'd0, 16'd0, 16'd0,
             sht_pkg::BOUND_NONE);
    send_req(OP_UNUSED, '1, 8'd1, 16'h3333, 8'd4, 16'd0, 16'd0, BOUND_EXACT);
    send_req(sht_pkg::OP_PROBE, '1, 8'd1, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_CLEAR, '1, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_PROBE, '1, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);
    send_req(sht_pkg::OP_PROBE, 64'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, sht_pkg::BOUND_NONE);

    for (int p = 0; p < 5; p++) begin
      set_threshold(phase_limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        steady = (p == 2) && (n < 200);
        random_req();
      end
      steady = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("search_hash_table_store: match");
    end else begin
      $display("search_hash_table_store: mismatch");
    end
    $finish;
  end

endmodule
